FILE: rtl/core/stok_pkg.sv
// Types, constants and character-class helpers shared by the source tokeniser.
package stok_pkg;

    // token kinds
    localparam logic [5:0] K_PLUS    = 6'd1;
    localparam logic [5:0] K_MINUS   = 6'd3;
    localparam logic [5:0] K_STAR    = 6'd5;
    localparam logic [5:0] K_SLASH   = 6'd7;
    localparam logic [5:0] K_PCT     = 6'd9;
    localparam logic [5:0] K_LPAR    = 6'd10;
    localparam logic [5:0] K_RPAR    = 6'd11;
    localparam logic [5:0] K_LBRACE  = 6'd12;
    localparam logic [5:0] K_RBRACE  = 6'd13;
    localparam logic [5:0] K_LBRK    = 6'd14;
    localparam logic [5:0] K_RBRK    = 6'd15;
    localparam logic [5:0] K_COLON   = 6'd16;
    localparam logic [5:0] K_SEMI    = 6'd17;
    localparam logic [5:0] K_COMMA   = 6'd18;
    localparam logic [5:0] K_DOT     = 6'd19;
    localparam logic [5:0] K_ASSIGN  = 6'd20;
    localparam logic [5:0] K_BANG    = 6'd22;
    localparam logic [5:0] K_LT      = 6'd24;
    localparam logic [5:0] K_GT      = 6'd26;
    localparam logic [5:0] K_ANDAND  = 6'd28;
    localparam logic [5:0] K_OROR    = 6'd29;
    localparam logic [5:0] K_INT     = 6'd30;
    localparam logic [5:0] K_FLOAT   = 6'd31;
    localparam logic [5:0] K_STR     = 6'd32;
    localparam logic [5:0] K_CHAR    = 6'd33;
    localparam logic [5:0] K_IDENT   = 6'd34;
    localparam logic [5:0] K_KW0     = 6'd35;
    localparam logic [5:0] K_END     = 6'd62;
    localparam logic [5:0] K_ERR     = 6'd63;
    localparam logic [5:0] K_NONE    = 6'd0;

    // error codes
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_AMP     = 3'd1;
    localparam logic [2:0] E_BAR     = 3'd2;
    localparam logic [2:0] E_UNEXP   = 3'd3;
    localparam logic [2:0] E_OPENSTR = 3'd4;
    localparam logic [2:0] E_ESCAPE  = 3'd5;
    localparam logic [2:0] E_BADCHAR = 3'd6;

    // characters
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_BAR   = "|";
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_USC   = "_";

    // largest value that may still take a digit of 7 or less
    localparam logic [63:0] NUM_Q   = 64'd922337203685477580;

    localparam int KW_COUNT = 27;
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        "object", "def", "val", "var", "if", "else", "match", "case", "class",
        "trait", "extends", "with", "return", "while", "for", "true", "false",
        "null", "Int", "Float", "Bool", "Char", "String", "Unit", "Option",
        "List", "Array"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd3, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd5, 3'd7, 3'd4,
        3'd6, 3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd6, 3'd4,
        3'd6, 3'd4, 3'd5
    };

    function automatic logic is_digit(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_word(logic [7:0] b);
        return is_alpha(b) || is_digit(b) || (b == CH_USC);
    endfunction

    function automatic logic [5:0] single_kind(logic [7:0] b);
        logic [5:0] k;
        case (b)
            "%":     k = K_PCT;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRK;
            "]":     k = K_RBRK;
            ":":     k = K_COLON;
            ";":     k = K_SEMI;
            ",":     k = K_COMMA;
            ".":     k = K_DOT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] h);
        logic [5:0] k;
        case (h)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "=":     k = K_ASSIGN;
            "!":     k = K_BANG;
            "<":     k = K_LT;
            ">":     k = K_GT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] op_second(logic [7:0] h);
        logic [7:0] s;
        if (h == CH_EQ) s = CH_GT;
        else if ((h == CH_AMP) || (h == CH_BAR)) s = h;
        else s = CH_EQ;
        return s;
    endfunction

endpackage

FILE: rtl/core/source_tokenizer.sv
// Source tokeniser: byte stream in, token stream out.
//
// Takes one source byte per transaction (tlast on the final byte) and gives
// token transactions. Each byte is decoded in the cycle it is taken and its
// zero to four tokens land in a four-slot result bank. While the receiver is
// ready the output side drains one token per cycle and bytes that give at most
// one token stream at one byte per cycle, as a new byte is taken when the bank
// will be empty after this cycle; others hold the input until one token is
// left. Two-character operators are emitted on their second byte; lone
// operators, numbers and identifiers on the byte after their end. After an
// error token the text is skipped up to the last byte, which always
// closes with an end token (tlast high) and resets the scanner. Offsets wrap
// at 2^POSITION_BITS; lines and columns saturate; all show their low 16 bits.
module source_tokenizer
    import stok_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] in_byte
    input  logic         i_s_tlast,   // in_last
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [5:0] token_kind, [8:6] error_code, [24:9] start_offset,
    // [40:25] token_length, [56:41] line_number, [72:57] column_number,
    // [135:73] int_value, [143:136] char_value
    output logic [143:0] o_m_tdata,
    output logic         o_m_tlast    // last_token
);

    localparam int P = POSITION_BITS;

    typedef logic [P-1:0] t_pos;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_NUM, M_NUMDOT, M_FLOAT, M_IDENT,
        M_STR, M_CHOPEN, M_CHESC, M_CHCLOSE
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  err;
        t_pos        start;
        t_pos        len;
        t_pos        line;
        t_pos        col;
        logic [62:0] iv;
        logic [7:0]  cv;
        logic        last;
    } t_tok;

    typedef struct packed {
        t_tok [3:0] res;
        logic [2:0] nr;
    } t_ebuf;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  held;
        t_pos        ts;
        t_pos        tcol;
        logic [63:0] acc;
        logic [26:0] kwc;
        logic [7:0]  esc;
        logic        err;
    } t_st;

    localparam t_st ST_RESET = '{
        mode: M_IDLE, held: '0, ts: '0, tcol: t_pos'(1), acc: '0,
        kwc: '1, esc: '0, err: 1'b0
    };

    function automatic t_tok tok(logic [5:0] kind, logic [2:0] err, t_pos start,
                                 t_pos len, t_pos line, t_pos col,
                                 logic [62:0] iv, logic [7:0] cv, logic last);
        t_tok t;
        t.kind = kind; t.err = err; t.start = start; t.len = len;
        t.line = line; t.col = col; t.iv = iv; t.cv = cv; t.last = last;
        return t;
    endfunction

    function automatic void emit(inout t_ebuf e, input t_tok t);
        if (e.nr < 3'd4) begin
            e.res[e.nr[1:0]] = t;
            e.nr = e.nr + 3'd1;
        end
    endfunction

    function automatic t_pos sat_add(t_pos a, t_pos b);
        logic [P:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[P] ? '1 : s[P-1:0];
    endfunction

    function automatic void fail(inout t_st s, inout t_ebuf e, input logic [2:0] code,
                                 input t_pos start, input t_pos col, input t_pos line);
        emit(e, tok(K_ERR, code, start, '0, line, col, '0, '0, 1'b0));
        s.err  = 1'b1;
        s.mode = M_IDLE;
    endfunction

    // drop keyword candidates that do not have byte b at position p
    function automatic logic [26:0] kw_upd(logic [26:0] c, t_pos p, logic [7:0] b);
        logic [26:0] r;
        logic [2:0]  j;
        r = c;
        for (int i = 0; i < KW_COUNT; i++) begin
            j = 3'(KW_LEN[i] - 3'd1 - p[2:0]);
            if (p >= t_pos'(KW_LEN[i])) r[i] = 1'b0;
            else if (KW_TEXT[i][{j, 3'b000} +: 8] != b) r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic void fin_num(inout t_st s, inout t_ebuf e, input t_pos len,
                                    input t_pos line);
        if (s.acc[63]) fail(s, e, E_BADCHAR, s.ts, s.tcol, line);
        else emit(e, tok(K_INT, E_NONE, s.ts, len, line, s.tcol, s.acc[62:0], '0, 1'b0));
    endfunction

    // close the token in progress; off is the offset just past it
    function automatic void finish(inout t_st s, inout t_ebuf e, input t_pos off,
                                   input t_pos line);
        t_pos       span;
        t_pos       len1;
        logic [5:0] kind;
        span = off - s.ts;
        len1 = span - t_pos'(1);
        kind = K_IDENT;
        case (s.mode)
            M_OP: begin
                if (s.held == CH_AMP) fail(s, e, E_AMP, s.ts, s.tcol, line);
                else if (s.held == CH_BAR) fail(s, e, E_BAR, s.ts, s.tcol, line);
                else emit(e, tok(op_kind(s.held), E_NONE, s.ts, t_pos'(1), line, s.tcol,
                                 '0, '0, 1'b0));
            end
            M_NUM: fin_num(s, e, span, line);
            M_NUMDOT: begin
                // "1." gives the integer then a dot
                fin_num(s, e, len1, line);
                if (!s.err)
                    emit(e, tok(K_DOT, E_NONE, s.ts + len1, t_pos'(1), line,
                                sat_add(s.tcol, len1), '0, '0, 1'b0));
            end
            M_FLOAT: emit(e, tok(K_FLOAT, E_NONE, s.ts, span, line, s.tcol, '0, '0, 1'b0));
            M_IDENT: begin
                for (int i = 0; i < KW_COUNT; i++)
                    if (s.kwc[i] && (t_pos'(KW_LEN[i]) == span)) kind = K_KW0 + 6'(i);
                emit(e, tok(kind, E_NONE, s.ts, span, line, s.tcol, '0, '0, 1'b0));
            end
            M_STR:     fail(s, e, E_OPENSTR, s.ts, s.tcol, line);
            M_CHESC:   fail(s, e, E_ESCAPE, s.ts, s.tcol, line);
            M_CHOPEN,
            M_CHCLOSE: fail(s, e, E_BADCHAR, s.ts, s.tcol, line);
            default: ;
        endcase
        s.mode = M_IDLE;
    endfunction

    function automatic logic [15:0] o16(t_pos v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    // state
    t_st         r_st, n_st;
    t_pos        r_off, n_off;
    t_pos        r_line, n_line;
    t_pos        r_col, n_col;
    // result bank
    t_tok        r_slot [4];
    logic [2:0]  r_cnt;
    logic [1:0]  r_rd;

    t_ebuf       eb;
    logic [7:0]  b;
    logic [3:0]  dig;
    logic        used;
    logic        nl;
    t_pos        span;
    logic        in_acc;
    logic        out_acc;

    assign out_acc    = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_m_tready);
    assign in_acc     = i_s_tvalid && o_s_tready;

    // per-byte decode
    always_comb begin
        n_st = r_st;
        eb   = '0;
        b    = i_s_tdata;
        dig  = 4'(b - CH_ZERO);
        used = 1'b0;
        nl   = 1'b0;
        span = r_off - r_st.ts;
        if (!n_st.err) begin
            case (n_st.mode)
                M_OP: begin
                    if (b == op_second(n_st.held)) begin
                        emit(eb, tok((n_st.held == CH_AMP) ? K_ANDAND :
                                     (n_st.held == CH_BAR) ? K_OROR :
                                     op_kind(n_st.held) + 6'd1,
                                     E_NONE, n_st.ts, t_pos'(2), r_line, n_st.tcol,
                                     '0, '0, 1'b0));
                        n_st.mode = M_IDLE;
                        used = 1'b1;
                    end else begin
                        finish(n_st, eb, r_off, r_line);
                    end
                end
                M_NUM: begin
                    if (is_digit(b)) begin
                        used = 1'b1;
                        if (!n_st.acc[63]) begin
                            if ((n_st.acc > NUM_Q) || ((n_st.acc == NUM_Q) && (dig > 4'd7)))
                                n_st.acc = 64'h8000_0000_0000_0000;
                            else
                                n_st.acc = (n_st.acc << 3) + (n_st.acc << 1) + 64'(dig);
                        end
                    end else if (b == CH_DOT) begin
                        n_st.mode = M_NUMDOT;
                        used = 1'b1;
                    end else begin
                        finish(n_st, eb, r_off, r_line);
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(b)) begin
                        n_st.mode = M_FLOAT;
                        used = 1'b1;
                    end else begin
                        finish(n_st, eb, r_off, r_line);
                    end
                end
                M_FLOAT: begin
                    if (is_digit(b)) used = 1'b1;
                    else finish(n_st, eb, r_off, r_line);
                end
                M_IDENT: begin
                    if (is_word(b)) begin
                        n_st.kwc = kw_upd(n_st.kwc, span, b);
                        used = 1'b1;
                    end else begin
                        finish(n_st, eb, r_off, r_line);
                    end
                end
                M_STR: begin
                    used = 1'b1;
                    if (b == CH_DQ) begin
                        emit(eb, tok(K_STR, E_NONE, n_st.ts, span, r_line, n_st.tcol,
                                     '0, '0, 1'b0));
                        n_st.mode = M_IDLE;
                    end
                end
                M_CHOPEN: begin
                    used = 1'b1;
                    if (b == CH_BSL) begin
                        n_st.mode = M_CHESC;
                    end else begin
                        n_st.esc  = b;
                        n_st.mode = M_CHCLOSE;
                    end
                end
                M_CHESC: begin
                    used = 1'b1;
                    n_st.mode = M_CHCLOSE;
                    case (b)
                        "n":     n_st.esc = CH_LF;
                        "t":     n_st.esc = CH_TAB;
                        "r":     n_st.esc = CH_CR;
                        "0":     n_st.esc = 8'h00;
                        CH_SQ, CH_DQ, CH_BSL: n_st.esc = b;
                        default: fail(n_st, eb, E_ESCAPE, n_st.ts, n_st.tcol, r_line);
                    endcase
                end
                M_CHCLOSE: begin
                    used = 1'b1;
                    if (b == CH_SQ) begin
                        emit(eb, tok(K_CHAR, E_NONE, n_st.ts, span + t_pos'(1), r_line,
                                     n_st.tcol, '0, n_st.esc, 1'b0));
                        n_st.mode = M_IDLE;
                    end else begin
                        fail(n_st, eb, E_BADCHAR, n_st.ts, n_st.tcol, r_line);
                    end
                end
                default: ;
            endcase

            // byte not part of the previous token: examine it between tokens
            if (!used && !n_st.err) begin
                if ((b == CH_SP) || (b == CH_TAB) || (b == CH_CR)) begin
                    nl = 1'b0;
                end else if (b == CH_LF) begin
                    nl = 1'b1;
                end else begin
                    n_st.ts   = r_off;
                    n_st.tcol = r_col;
                    if ((op_kind(b) != K_NONE) || (b == CH_AMP) || (b == CH_BAR)) begin
                        n_st.held = b;
                        n_st.mode = M_OP;
                    end else if (single_kind(b) != K_NONE) begin
                        emit(eb, tok(single_kind(b), E_NONE, r_off, t_pos'(1), r_line,
                                     r_col, '0, '0, 1'b0));
                    end else if (b == CH_DQ) begin
                        n_st.ts   = r_off + t_pos'(1);
                        n_st.mode = M_STR;
                    end else if (b == CH_SQ) begin
                        n_st.mode = M_CHOPEN;
                    end else if (is_digit(b)) begin
                        n_st.acc  = 64'(dig);
                        n_st.mode = M_NUM;
                    end else if (is_alpha(b) || (b == CH_USC)) begin
                        n_st.kwc  = kw_upd('1, '0, b);
                        n_st.mode = M_IDENT;
                    end else begin
                        fail(n_st, eb, E_UNEXP, r_off, r_col, r_line);
                    end
                end
            end
        end

        n_off = r_off + t_pos'(1);
        if (nl) begin
            n_line = (r_line != '1) ? r_line + t_pos'(1) : r_line;
            n_col  = t_pos'(1);
        end else begin
            n_line = r_line;
            n_col  = sat_add(r_col, t_pos'(1));
        end

        if (i_s_tlast) begin
            if (!n_st.err) finish(n_st, eb, n_off, n_line);
            emit(eb, tok(K_END, E_NONE, n_off, '0, n_line, n_col, '0, '0, 1'b1));
            n_st   = ST_RESET;
            n_off  = '0;
            n_line = t_pos'(1);
            n_col  = t_pos'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_RESET;
            r_off  <= '0;
            r_line <= t_pos'(1);
            r_col  <= t_pos'(1);
            r_cnt  <= '0;
            r_rd   <= '0;
        end else if (in_acc) begin
            r_st   <= n_st;
            r_off  <= n_off;
            r_line <= n_line;
            r_col  <= n_col;
            r_cnt  <= eb.nr;
            r_rd   <= '0;
        end else if (out_acc) begin
            r_cnt  <= r_cnt - 3'd1;
            r_rd   <= r_rd + 2'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < 4; k++) r_slot[k] <= eb.res[k];
        end
    end

    t_tok cur;
    assign cur        = r_slot[r_rd];
    assign o_m_tvalid = (r_cnt != 3'd0);
    assign o_m_tlast  = cur.last;
    assign o_m_tdata  = {cur.cv, cur.iv, o16(cur.col), o16(cur.line), o16(cur.len),
                         o16(cur.start), cur.err, cur.kind};

endmodule

FILE: dv/tb_source_tokenizer.sv
// Self-checking testbench for the source tokeniser: directed table, then random source text.
module tb_source_tokenizer;
    import stok_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = 16;
    localparam logic [31:0] PMASK = 32'h0000_FFFF;
    localparam logic [63:0] INT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [5:0] K_ARROW = K_ASSIGN + 6'd1;

    // scanner modes of the predictor
    typedef enum logic [3:0] {
        SM_IDLE, SM_OP, SM_NUM, SM_NUMDOT, SM_FLOAT, SM_IDENT,
        SM_STR, SM_CHOPEN, SM_CHESC, SM_CHCLOSE
    } scan_mode_e;

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [62:0] ival;
        logic [7:0]  cval;
        logic        last;
    } token_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata = '0;   // [7:0] in_byte
    logic         i_s_tlast = 1'b0; // in_last
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // [5:0] kind, [8:6] error, [24:9] start, [40:25] length, [56:41] line,
    // [72:57] column, [135:73] int value, [143:136] char value
    logic [143:0] o_m_tdata;
    logic         o_m_tlast;        // last_token

    source_tokenizer #(.POSITION_BITS(PB)) u_dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    scan_mode_e  mode;
    logic [7:0]  held;
    logic [31:0] boff, tstart, cline, ccol, tcol;
    logic [63:0] acc;
    logic [26:0] kwc;
    logic [7:0]  escv;
    bit          err_seen;

    token_t      expected_tokens[$];
    token_t      step_tokens[$];
    int          failures = 0;
    longint      cycles = 0;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 0;

    // keyword table, also used by the generator
    string kw_words[27] = '{"object", "def", "val", "var", "if", "else", "match", "case",
        "class", "trait", "extends", "with", "return", "while", "for", "true", "false",
        "null", "Int", "Float", "Bool", "Char", "String", "Unit", "Option", "List",
        "Array"};

    function automatic bit dig(logic [7:0] b); return b >= "0" && b <= "9"; endfunction
    function automatic bit alp(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic bit wrd(logic [7:0] b); return alp(b) || dig(b) || b == "_"; endfunction

    function automatic logic [5:0] punct_kind(logic [7:0] b);
        case (b)
            "%": return K_PCT;    "(": return K_LPAR;   ")": return K_RPAR;
            "{": return K_LBRACE; "}": return K_RBRACE; "[": return K_LBRK;
            "]": return K_RBRK;   ":": return K_COLON;  ";": return K_SEMI;
            ",": return K_COMMA;  ".": return K_DOT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [5:0] oper_kind(logic [7:0] b);
        case (b)
            "+": return K_PLUS;   "-": return K_MINUS; "*": return K_STAR;
            "/": return K_SLASH;  "=": return K_ASSIGN; "!": return K_BANG;
            "<": return K_LT;     ">": return K_GT;
            default: return K_NONE;
        endcase
    endfunction

    function automatic logic [7:0] oper_follow(logic [7:0] h);
        if (h == CH_EQ) return CH_GT;
        if (h == CH_AMP || h == CH_BAR) return h;
        return CH_EQ;
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a & PMASK} + {1'b0, b & PMASK};
        return (s > PMASK) ? PMASK : s[31:0];
    endfunction

    function automatic logic [31:0] span(); return (boff - tstart) & PMASK; endfunction

    function automatic void put_token(logic [5:0] k, logic [2:0] e, logic [31:0] st,
                                      logic [31:0] ln, logic [31:0] col, logic [63:0] iv,
                                      logic [7:0] cv, logic lst);
        token_t t;
        if (step_tokens.size() >= 4) return;
        t.kind = k; t.err = e; t.start = st[15:0]; t.len = ln[15:0];
        t.line = cline[15:0]; t.col = col[15:0]; t.ival = iv[62:0];
        t.cval = cv; t.last = lst;
        step_tokens = {step_tokens, t};
    endfunction

    function automatic void raise_error(logic [2:0] code, logic [31:0] st, logic [31:0] col);
        put_token(K_ERR, code, st, 0, col, 0, 0, 0);
        err_seen = 1;
        mode = SM_IDLE;
    endfunction

    function automatic void scanner_reset();
        mode = SM_IDLE; held = 0; boff = 0; tstart = 0; cline = 1; ccol = 1;
        tcol = 1; acc = 0; kwc = '1; escv = 0; err_seen = 0;
    endfunction

    function automatic void close_oper();
        mode = SM_IDLE;
        if (held == CH_AMP) raise_error(E_AMP, tstart, tcol);
        else if (held == CH_BAR) raise_error(E_BAR, tstart, tcol);
        else put_token(oper_kind(held), E_NONE, tstart, 1, tcol, 0, 0, 0);
    endfunction

    function automatic void close_number(logic [31:0] ln);
        mode = SM_IDLE;
        if (acc[63]) raise_error(E_BADCHAR, tstart, tcol);
        else put_token(K_INT, E_NONE, tstart, ln, tcol, acc, 0, 0);
    endfunction

    // "12." followed by a non-digit: integer then a dot
    function automatic void close_number_dot();
        logic [31:0] ln;
        ln = (span() - 1) & PMASK;
        close_number(ln);
        if (!err_seen) put_token(K_DOT, E_NONE, tstart + ln, 1, sat_inc(tcol, ln), 0, 0, 0);
    endfunction

    function automatic void narrow_keywords(logic [31:0] p, logic [7:0] b);
        string w;
        for (int i = 0; i < 27; i++) begin
            w = kw_words[i];
            if (kwc[i] && (p >= w.len() || w[p] != b)) kwc[i] = 0;
        end
    endfunction

    function automatic void close_ident();
        logic [31:0] ln;
        logic [5:0] k;
        ln = span();
        k = K_IDENT;
        for (int i = 0; i < 27; i++)
            if (kwc[i] && kw_words[i].len() == ln) k = K_KW0 + 6'(i);
        mode = SM_IDLE;
        put_token(k, E_NONE, tstart, ln, tcol, 0, 0, 0);
    endfunction

    function automatic void push_digit(logic [7:0] b);
        logic [63:0] d;
        d = 64'(b - "0");
        if (acc[63]) return;
        if (acc > (INT_LIMIT - d) / 10) acc = 64'h8000_0000_0000_0000;
        else acc = acc * 10 + d;
    endfunction

    function automatic bit extend_token(logic [7:0] b);
        case (mode)
            SM_OP: begin
                if (b == oper_follow(held)) begin
                    mode = SM_IDLE;
                    put_token(held == CH_AMP ? K_ANDAND : held == CH_BAR ? K_OROR :
                              oper_kind(held) + 6'd1, E_NONE, tstart, 2, tcol, 0, 0, 0);
                    return 1;
                end
                close_oper();
                return 0;
            end
            SM_NUM: begin
                if (dig(b)) begin push_digit(b); return 1; end
                if (b == CH_DOT) begin mode = SM_NUMDOT; return 1; end
                close_number(span());
                return 0;
            end
            SM_NUMDOT: begin
                if (dig(b)) begin mode = SM_FLOAT; return 1; end
                close_number_dot();
                return 0;
            end
            SM_FLOAT: begin
                if (dig(b)) return 1;
                mode = SM_IDLE;
                put_token(K_FLOAT, E_NONE, tstart, span(), tcol, 0, 0, 0);
                return 0;
            end
            SM_IDENT: begin
                if (wrd(b)) begin narrow_keywords(span(), b); return 1; end
                close_ident();
                return 0;
            end
            SM_STR: begin
                if (b == CH_DQ) begin
                    mode = SM_IDLE;
                    put_token(K_STR, E_NONE, tstart, span(), tcol, 0, 0, 0);
                end
                return 1;
            end
            SM_CHOPEN: begin
                if (b == CH_BSL) mode = SM_CHESC;
                else begin escv = b; mode = SM_CHCLOSE; end
                return 1;
            end
            SM_CHESC: begin
                case (b)
                    "n": escv = CH_LF;
                    "t": escv = CH_TAB;
                    "r": escv = CH_CR;
                    "0": escv = 0;
                    CH_SQ, CH_DQ, CH_BSL: escv = b;
                    default: begin raise_error(E_ESCAPE, tstart, tcol); return 1; end
                endcase
                mode = SM_CHCLOSE;
                return 1;
            end
            SM_CHCLOSE: begin
                if (b == CH_SQ) begin
                    mode = SM_IDLE;
                    put_token(K_CHAR, E_NONE, tstart, span() + 1, tcol, 0, escv, 0);
                end else raise_error(E_BADCHAR, tstart, tcol);
                return 1;
            end
            default: begin mode = SM_IDLE; return 0; end
        endcase
    endfunction

    // returns 1 for a newline between tokens
    function automatic bit begin_token(logic [7:0] b);
        logic [5:0] k;
        if (b == CH_SP || b == CH_TAB || b == CH_CR) return 0;
        if (b == CH_LF) return 1;
        tstart = boff;
        tcol = ccol;
        if (oper_kind(b) != K_NONE || b == CH_AMP || b == CH_BAR) begin
            held = b; mode = SM_OP; return 0;
        end
        k = punct_kind(b);
        if (k != K_NONE) begin put_token(k, E_NONE, boff, 1, ccol, 0, 0, 0); return 0; end
        if (b == CH_DQ) begin tstart = (boff + 1) & PMASK; mode = SM_STR; return 0; end
        if (b == CH_SQ) begin mode = SM_CHOPEN; return 0; end
        if (dig(b)) begin acc = 64'(b - "0"); mode = SM_NUM; return 0; end
        if (alp(b) || b == CH_USC) begin
            kwc = '1; narrow_keywords(0, b); mode = SM_IDENT; return 0;
        end
        raise_error(E_UNEXP, boff, ccol);
        return 0;
    endfunction

    function automatic void flush_pending();
        case (mode)
            SM_OP:      close_oper();
            SM_NUM:     close_number(span());
            SM_NUMDOT:  close_number_dot();
            SM_FLOAT:   put_token(K_FLOAT, E_NONE, tstart, span(), tcol, 0, 0, 0);
            SM_IDENT:   close_ident();
            SM_STR:     raise_error(E_OPENSTR, tstart, tcol);
            SM_CHESC:   raise_error(E_ESCAPE, tstart, tcol);
            SM_CHOPEN, SM_CHCLOSE: raise_error(E_BADCHAR, tstart, tcol);
            default: ;
        endcase
        mode = SM_IDLE;
    endfunction

    // tokens that one accepted byte gives, left in step_tokens
    function automatic void predict_tokens(logic [7:0] b, logic lst);
        bit nl;
        nl = 0;
        step_tokens.delete();
        if (!err_seen) begin
            if (!extend_token(b) && !err_seen) nl = begin_token(b);
        end
        boff = (boff + 1) & PMASK;
        if (nl) begin
            if (cline < PMASK) cline++;
            ccol = 1;
        end else ccol = sat_inc(ccol, 1);
        if (lst) begin
            if (!err_seen) flush_pending();
            put_token(K_END, E_NONE, boff, 0, ccol, 0, 0, 1);
            scanner_reset();
        end
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_source_tokenizer: FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // token checker
    always @(posedge i_clk) begin
        token_t got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[5:0], o_m_tdata[8:6], o_m_tdata[24:9], o_m_tdata[40:25],
                   o_m_tdata[56:41], o_m_tdata[72:57], o_m_tdata[135:73],
                   o_m_tdata[143:136], o_m_tlast};
            if (expected_tokens.size() == 0) begin
                failures++;
                $display("%0t: unexpected token, expected none, actual %p", $time, got);
            end else begin
                want = expected_tokens.pop_front();
                if (got !== want) begin
                    failures++;
                    $display("%0t: token mismatch, expected %p, actual %p", $time, want, got);
                end
            end
        end
    end

    // one byte transaction; prediction is queued on acceptance
    task automatic send_byte(logic [7:0] b, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        predict_tokens(b, lst);
        expected_tokens = {expected_tokens, step_tokens};
    endtask

    task automatic send_text(string s, bit lst);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], lst && i == s.len() - 1);
    endtask

    // sender goes quiet until every expected token has come out
    task automatic drain_all();
        i_s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    // random lexeme, mostly well formed
    function automatic string random_lexeme();
        string s, ops, esc_chars, ws_chars;
        int n;
        ops = "+-*/=!<>&|%(){}[]:;,.";
        esc_chars = "ntr0'\"\\q";
        ws_chars = " \t\r\n";
        case ($urandom_range(11))
            0: s = kw_words[$urandom_range(26)];
            1, 2: begin
                s = "";
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(0, 2) == 0 ? "_" :
                        $urandom_range(0, 1) ? "a" + $urandom_range(25) :
                        "A" + $urandom_range(25)))};
            end
            3: s = $sformatf("%0d", $urandom_range(0, 99999));
            4: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
            5: begin
                s = {string'(ops[$urandom_range(ops.len() - 1)])};
                if ($urandom_range(1)) s = {s, string'(ops[$urandom_range(9)])};
            end
            6: s = {"\"", kw_words[$urandom_range(26)], " x\""};
            7: s = $urandom_range(1) ? {"'", string'(8'($urandom_range(33, 126))), "'"}
                                     : {"'\\", string'(esc_chars[$urandom_range(7)]), "'"};
            8: s = {string'(ws_chars[$urandom_range(3)])};
            9: s = $urandom_range(1) ? "9223372036854775808" : "9223372036854775807";
            10: s = "x";
            default: s = {string'(8'($urandom_range(255)))};  // noise
        endcase
        return s;
    endfunction

    typedef struct {
        logic [7:0] b;
        logic       lst;
        logic [5:0] kind;   // K_NONE: predictor only
        logic [2:0] err;
    } row_t;

    // directed rows; a typed kind is checked against the first predicted token of that byte
    row_t dir_rows[] = '{
        '{8'h00, 1, K_ERR, E_UNEXP}, '{8'hFF, 1, K_ERR, E_UNEXP},
        '{"&", 1, K_ERR, E_AMP},     '{"|", 1, K_ERR, E_BAR},
        '{"&", 0, K_NONE, E_NONE},   '{"&", 0, K_ANDAND, E_NONE},
        '{"=", 0, K_NONE, E_NONE},   '{">", 0, K_ARROW, E_NONE},
        '{"!", 0, K_NONE, E_NONE},   '{"=", 0, K_NONE, E_NONE},
        '{"7", 0, K_NONE, E_NONE},   '{".", 0, K_NONE, E_NONE},
        '{";", 1, K_INT, E_NONE},    '{"\"", 0, K_NONE, E_NONE},
        '{8'h80, 1, K_ERR, E_OPENSTR}, '{"'", 0, K_NONE, E_NONE},
        '{"\\", 0, K_NONE, E_NONE},  '{"q", 1, K_ERR, E_ESCAPE},
        '{"'", 0, K_NONE, E_NONE},   '{"\\", 1, K_ERR, E_ESCAPE},
        '{"'", 0, K_NONE, E_NONE},   '{"a", 0, K_NONE, E_NONE},
        '{"b", 1, K_ERR, E_BADCHAR}, '{"\n", 1, K_END, E_NONE}
    };

    initial begin
        string text;
        int n_items;
        scanner_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            send_byte(dir_rows[r].b, dir_rows[r].lst);
            if (dir_rows[r].kind != K_NONE &&
                (step_tokens.size() == 0 || step_tokens[0].kind != dir_rows[r].kind ||
                 step_tokens[0].err != dir_rows[r].err)) begin
                failures++;
                $display("%0t: row %0d, expected kind %0d err %0d, actual prediction %p",
                         $time, r, dir_rows[r].kind, dir_rows[r].err, step_tokens);
            end
        end
        send_text("val x=1.5 \"s\\n\" '\\'' Option extends 9223372036854775808 ", 1);
        send_text("1.", 1);
        drain_all();

        // pause until drained, then random phases
        n_items = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) begin
                fork
                    begin hold_off = 1; repeat (60) @(posedge i_clk); hold_off = 0; end
                    send_text("a+=b;c<=d(e)!x", 1);
                join
            end
            while (n_items < (ph + 1) * 54) begin
                text = random_lexeme();
                if ($urandom_range(0, 3) != 0) text = {text, " "};
                if ($urandom_range(0, 12) == 0) text = {text, "\n"};
                for (int i = 0; i < text.len(); i++) begin
                    send_byte(text[i], $urandom_range(0, 40) == 0);
                    n_items++;
                end
            end
            send_byte(" ", 1);
            drain_all();
        end

        repeat (20) @(posedge i_clk);
        if (failures == 0 && expected_tokens.size() == 0) begin
            $display("tb_source_tokenizer: PASS");
        end else begin
            $display("tb_source_tokenizer: FAIL");
        end
        $finish;
    end

endmodule
